FILE: hdl/att_pkg.sv
package att_pkg;

  // table geometry, the fifo depth is a power of two so slot arithmetic wraps
  localparam int PEERS            = 16;
  localparam int MODULES          = 8;
  localparam int POINTS_PER_ENTRY = 8;
  localparam int TIME_BITS        = 48;
  localparam int ENTRIES          = PEERS * MODULES;
  localparam int EW               = $clog2(ENTRIES);
  localparam int PW               = $clog2(POINTS_PER_ENTRY);
  localparam int CW               = $clog2(POINTS_PER_ENTRY + 1);
  localparam int MW               = $clog2(MODULES);

  // request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [2:0] CFG_DEFAULT   = 3'd0;
  localparam logic [2:0] CFG_MAX       = 3'd1;
  localparam logic [2:0] CFG_WINDOW    = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_RAISE     = 3'd4;
  localparam logic [2:0] CFG_LOWER     = 3'd5;

  localparam logic [15:0] RST_DEFAULT   = 16'd10000;
  localparam logic [15:0] RST_MAX       = 16'd30000;
  localparam logic [15:0] RST_WINDOW    = 16'd5000;
  localparam logic [7:0]  RST_THRESHOLD = 8'd10;
  localparam logic [15:0] RST_RAISE     = 16'd5000;
  localparam logic [15:0] RST_LOWER     = 16'd500;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ADD,
    ST_QUERY,
    ST_REMOVE,
    ST_TICK_ENTRY,
    ST_TICK_CHECK,
    ST_TICK_READ,
    ST_TICK_POP,
    ST_TICK_ADAPT,
    ST_OUT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_req;    // latch the accepted word
    logic rd_entry;    // read the addressed entry record
    logic do_add;      // perform the add on the looked-up entry
    logic rm_clear;    // clear entry at the remove cursor
    logic rm_next;     // advance the remove cursor
    logic tk_start;    // reset the tick walk
    logic tk_fetch;    // read the record of the walked entry
    logic tk_read;     // issue point memory read at the entry head
    logic tk_pop;      // consume the point just read
    logic tk_adapt;    // update timeout of the walked entry
    logic tk_next;     // advance to the next entry
    logic out_load;    // capture the result word
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] req;
    logic rm_last;
    logic tk_present;  // walked entry is present
    logic tk_has_pt;   // walked entry has points left
    logic tk_older;    // point just read is earlier than now
    logic tk_last;     // walked entry is the last one
  } stat_t;

endpackage

FILE: hdl/att_ctrl.sv
module att_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_busy,
  input  att_pkg::stat_t    stat,
  output att_pkg::cmd_t     cmd,
  output logic              idle
);

  att_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= att_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      att_pkg::ST_IDLE: begin
        idle = !out_busy;
        if (in_fire) begin
          cmd.load_req = 1'b1;
          state_next = att_pkg::ST_LOOKUP;
        end
      end
      att_pkg::ST_LOOKUP: begin
        case (stat.req)
          att_pkg::REQ_ADD: begin
            cmd.rd_entry = 1'b1;
            state_next = att_pkg::ST_ADD;
          end
          att_pkg::REQ_TICK: begin
            cmd.tk_start = 1'b1;
            state_next = att_pkg::ST_TICK_ENTRY;
          end
          att_pkg::REQ_REMOVE: state_next = att_pkg::ST_REMOVE;
          default: begin
            cmd.rd_entry = 1'b1;
            state_next = att_pkg::ST_QUERY;
          end
        endcase
      end
      att_pkg::ST_ADD: begin
        cmd.do_add = 1'b1;
        cmd.out_load = 1'b1;
        state_next = att_pkg::ST_OUT;
      end
      att_pkg::ST_QUERY: begin
        cmd.out_load = 1'b1;
        state_next = att_pkg::ST_OUT;
      end
      att_pkg::ST_REMOVE: begin
        cmd.rm_clear = 1'b1;
        cmd.rm_next = 1'b1;
        if (stat.rm_last) begin
          cmd.out_load = 1'b1;
          state_next = att_pkg::ST_OUT;
        end
      end
      att_pkg::ST_TICK_ENTRY: begin
        if (!stat.tk_present) begin
          cmd.tk_next = 1'b1;
          if (stat.tk_last) begin
            cmd.out_load = 1'b1;
            state_next = att_pkg::ST_OUT;
          end
        end else begin
          cmd.tk_fetch = 1'b1;
          state_next = att_pkg::ST_TICK_CHECK;
        end
      end
      att_pkg::ST_TICK_CHECK: begin
        if (stat.tk_has_pt) begin
          cmd.tk_read = 1'b1;
          state_next = att_pkg::ST_TICK_READ;
        end else begin
          state_next = att_pkg::ST_TICK_ADAPT;
        end
      end
      att_pkg::ST_TICK_READ: state_next = att_pkg::ST_TICK_POP;
      att_pkg::ST_TICK_POP: begin
        if (stat.tk_older) begin
          cmd.tk_pop = 1'b1;
          state_next = att_pkg::ST_TICK_CHECK;
        end else begin
          state_next = att_pkg::ST_TICK_ADAPT;
        end
      end
      att_pkg::ST_TICK_ADAPT: begin
        cmd.tk_adapt = 1'b1;
        cmd.tk_next = 1'b1;
        if (stat.tk_last) begin
          cmd.out_load = 1'b1;
          state_next = att_pkg::ST_OUT;
        end else begin
          state_next = att_pkg::ST_TICK_ENTRY;
        end
      end
      att_pkg::ST_OUT: begin
        if (!out_busy) state_next = att_pkg::ST_IDLE;
      end
      default: state_next = att_pkg::ST_IDLE;
    endcase
  end

  // a word is taken only from idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |-> state == att_pkg::ST_IDLE)
    else $error("request latched outside idle");
  // a result is captured only when the output stage is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_busy)
    else $error("result captured over a pending one");
  // a pop always follows a memory read
  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    cmd.tk_pop |-> $past(cmd.tk_read, 2))
    else $error("pop without read");

endmodule

FILE: hdl/att_dp.sv
module att_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  att_pkg::cmd_t                   cmd,
  output att_pkg::stat_t                  stat,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_addr,
  input  logic [15:0]                     cfg_data,
  input  logic [1:0]                      in_req_type,
  input  logic [3:0]                      in_peer,
  input  logic [2:0]                      in_module_req,
  input  logic [att_pkg::TIME_BITS-1:0]   in_timestamp,
  output logic [15:0]                     res_timeout_ms,
  output logic                            res_known,
  output logic                            res_dropped
);

  localparam int TB  = att_pkg::TIME_BITS;
  localparam int EW  = att_pkg::EW;
  localparam int PW  = att_pkg::PW;
  localparam int CW  = att_pkg::CW;
  localparam int MW  = att_pkg::MW;
  localparam int PTS = att_pkg::ENTRIES * att_pkg::POINTS_PER_ENTRY;
  localparam int EMW = 16 + PW + CW;

  // configuration registers
  logic [15:0] default_timeout, max_timeout, window_ms, raise_step, lower_step;
  logic [7:0]  raise_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= att_pkg::RST_DEFAULT;
      max_timeout     <= att_pkg::RST_MAX;
      window_ms       <= att_pkg::RST_WINDOW;
      raise_threshold <= att_pkg::RST_THRESHOLD;
      raise_step      <= att_pkg::RST_RAISE;
      lower_step      <= att_pkg::RST_LOWER;
    end else if (cfg_we) begin
      case (cfg_addr)
        att_pkg::CFG_DEFAULT:   default_timeout <= cfg_data;
        att_pkg::CFG_MAX:       max_timeout <= cfg_data;
        att_pkg::CFG_WINDOW:    window_ms <= cfg_data;
        att_pkg::CFG_THRESHOLD: raise_threshold <= cfg_data[7:0];
        att_pkg::CFG_RAISE:     raise_step <= cfg_data;
        att_pkg::CFG_LOWER:     lower_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic [1:0]    req;
  logic [3:0]    peer;
  logic [2:0]    mod;
  logic [TB-1:0] ts;
  logic [EW-1:0] eidx;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req  <= in_req_type;
      peer <= in_peer;
      mod  <= in_module_req;
      ts   <= in_timestamp;
    end
  end

  // every peer and module code maps to an entry
  assign eidx = {peer, mod};

  // presence flags, the entry record is only trusted while present
  logic          epres [att_pkg::ENTRIES];

  // entry records {timeout, head, count} with a registered read port
  logic [EMW-1:0] emem [att_pkg::ENTRIES];
  logic [15:0]    e_tmo;
  logic [PW-1:0]  e_head;
  logic [CW-1:0]  e_cnt;

  // point memory
  logic [TB-1:0] pmem [PTS];
  logic [TB-1:0] prd;

  // tick and remove cursors
  logic [EW-1:0] cur;
  logic [MW-1:0] rm_mod;
  logic [7:0]    counted;
  logic [EW-1:0] rm_idx;

  assign rm_idx = {peer, rm_mod};

  // add helpers
  logic          a_pres;
  logic [CW-1:0] a_cnt, a_cnt_next;
  logic [PW-1:0] a_head, a_slot;
  logic          a_full;
  logic [15:0]   a_tmo;
  assign a_pres     = epres[eidx];
  assign a_cnt      = a_pres ? e_cnt : '0;
  assign a_head     = a_pres ? e_head : '0;
  assign a_tmo      = a_pres ? e_tmo : default_timeout;
  assign a_full     = a_cnt >= CW'(att_pkg::POINTS_PER_ENTRY);
  assign a_slot     = a_head + a_cnt[PW-1:0];
  assign a_cnt_next = a_full ? a_cnt : a_cnt + 1'b1;

  // tick helpers
  logic          have_start;
  logic [TB-1:0] start;
  logic [PW-1:0] head_next;
  logic [16:0]   up_sum;
  logic [15:0]   up_v, dn_v, adapt_v;
  assign have_start = ts >= TB'(window_ms);
  assign start      = ts - TB'(window_ms);
  assign head_next  = e_head + 1'b1;
  assign up_sum     = {1'b0, e_tmo} + {1'b0, raise_step};
  assign up_v       = (up_sum > {1'b0, max_timeout}) ? max_timeout : up_sum[15:0];
  assign dn_v       = (e_tmo > lower_step) ? e_tmo - lower_step : 16'd0;
  assign adapt_v    = (counted > raise_threshold) ? up_v
                    : ((dn_v < default_timeout) ? default_timeout : dn_v);

  // presence flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < att_pkg::ENTRIES; i++) epres[i] <= 1'b0;
    end else begin
      if (cmd.do_add) epres[eidx] <= 1'b1;
      if (cmd.rm_clear) epres[rm_idx] <= 1'b0;
    end
  end

  // entry record write port
  always_ff @(posedge clk) begin
    if (cmd.do_add) emem[eidx] <= {a_tmo, a_head, a_cnt_next};
    else if (cmd.tk_adapt) emem[cur] <= {adapt_v, e_head, e_cnt};
  end

  // entry record read port, head and count advance on a pop
  always_ff @(posedge clk) begin
    if (cmd.rd_entry) begin
      {e_tmo, e_head, e_cnt} <= emem[eidx];
    end else if (cmd.tk_fetch) begin
      {e_tmo, e_head, e_cnt} <= emem[cur];
    end else if (cmd.tk_pop) begin
      e_head <= head_next;
      e_cnt  <= e_cnt - 1'b1;
    end
  end

  // point memory port
  always_ff @(posedge clk) begin
    if (cmd.do_add && !a_full) pmem[{eidx, a_slot}] <= ts;
    if (cmd.tk_read) prd <= pmem[{cur, e_head}];
  end

  // cursors and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      rm_mod <= '0;
      counted <= '0;
    end else begin
      if (cmd.load_req) rm_mod <= '0;
      else if (cmd.rm_next) rm_mod <= rm_mod + 1'b1;
      if (cmd.tk_start) begin
        cur <= '0;
        counted <= '0;
      end else if (cmd.tk_next) begin
        cur <= cur + 1'b1;
        counted <= '0;
      end else if (cmd.tk_pop && have_start && prd >= start && counted != 8'hff) begin
        counted <= counted + 1'b1;
      end
    end
  end

  // status
  assign stat.req        = req;
  assign stat.rm_last    = rm_mod == MW'(att_pkg::MODULES - 1);
  assign stat.tk_present = epres[cur];
  assign stat.tk_has_pt  = e_cnt != '0;
  assign stat.tk_older   = prd < ts;
  assign stat.tk_last    = cur == EW'(att_pkg::ENTRIES - 1);

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_timeout_ms <= 16'd0;
      res_known      <= 1'b0;
      res_dropped    <= 1'b0;
      case (req)
        att_pkg::REQ_ADD: begin
          res_timeout_ms <= a_tmo;
          res_known      <= a_pres;
          res_dropped    <= a_full;
        end
        att_pkg::REQ_QUERY: begin
          res_timeout_ms <= a_tmo;
          res_known      <= a_pres;
        end
        default: ;
      endcase
    end
  end

  // fill count never exceeds the fifo depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.do_add |-> a_cnt <= CW'(att_pkg::POINTS_PER_ENTRY))
    else $error("fifo count overflow");
  // a pop only happens on an entry with points
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.tk_pop |-> e_cnt != '0)
    else $error("pop from empty fifo");
  // adapted timeout is at most the cap, equals the default, or is at most the lowered timeout
  a_adapt_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.tk_adapt |-> (adapt_v <= max_timeout || adapt_v == default_timeout
                      || adapt_v <= dn_v))
    else $error("adapted timeout out of range");

endmodule

FILE: hdl/adaptive_timeout_table.sv
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: req_type, peer, module_req, timestamp
// m_axis    out  tvalid/tready          tdata: timeout_ms, known, dropped
// cfg       in   cfg_we (no wait)       cfg_addr, cfg_data
//
// add, query: lookup, entry read, then the result word; remove: lookup, then a clear of each
// module entry of the peer. tick: lookup, then a walk over every entry; an absent entry is
// skipped, a present one has its record read, each point older than now popped and its
// timeout updated. one request at a time; the next word is taken once the result word has
// been accepted and the controller is back in idle.
// rst is synchronous and clears the entry presence flags.
// a stalled m_axis holds the result and blocks new requests.
module adaptive_timeout_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // req_type[1:0], peer[5:2], module_req[8:6], timestamp[56:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // timeout_ms[15:0], known[16], dropped[17]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  att_pkg::cmd_t  cmd;
  att_pkg::stat_t stat;
  logic           idle, in_fire;
  logic [15:0]    res_timeout_ms;
  logic           res_known, res_dropped;
  logic           out_busy;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) out_busy <= 1'b0;
    else if (cmd.out_load) out_busy <= 1'b1;
    else if (m_axis_tready) out_busy <= 1'b0;
  end

  assign m_axis_tvalid = out_busy;
  assign m_axis_tdata  = {6'd0, res_dropped, res_known, res_timeout_ms};

  att_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_busy),
    .stat(stat), .cmd(cmd), .idle(idle)
  );

  att_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_req_type(s_axis_tdata[1:0]), .in_peer(s_axis_tdata[5:2]),
    .in_module_req(s_axis_tdata[8:6]), .in_timestamp(s_axis_tdata[56:9]),
    .res_timeout_ms(res_timeout_ms), .res_known(res_known),
    .res_dropped(res_dropped)
  );

endmodule

FILE: tb/att_checker.sv
module att_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = att_pkg::ENTRIES;
  localparam int DEPTH = att_pkg::POINTS_PER_ENTRY;

  typedef struct {
    att_pkg::req_t req;
    logic [15:0]   timeout_ms;
    logic          known;
    logic          dropped;
  } verdict_t;

  // shadow copy of the register file
  logic [15:0] dflt_tmo, max_tmo, window, up_step, down_step;
  logic [7:0]  threshold;

  // shadow copy of the entry table
  logic [15:0] tmo_tab [ENTRIES];
  bit          present [ENTRIES];
  logic [47:0] points  [ENTRIES][DEPTH];
  int          head    [ENTRIES];
  int          cnt     [ENTRIES];

  verdict_t expected_q[$];

  // pop aged points of one entry and move its timeout up or down
  function automatic void adapt_timeout(int e, logic [47:0] now);
    int   hits;
    bit   in_window;
    logic [47:0] start, t;
    int   cur;
    hits = 0;
    in_window = now >= {32'd0, window};
    start = now - {32'd0, window};
    while (cnt[e] > 0) begin
      t = points[e][head[e]];
      if (t >= now) break;
      if (in_window && t >= start) hits++;
      head[e] = (head[e] + 1) % DEPTH;
      cnt[e]--;
    end
    cur = int'(tmo_tab[e]);
    if (hits > int'(threshold)) begin
      cur = cur + int'(up_step);
      if (cur > int'(max_tmo)) cur = int'(max_tmo);
    end else begin
      cur = (cur > int'(down_step)) ? cur - int'(down_step) : 0;
      if (cur < int'(dflt_tmo)) cur = int'(dflt_tmo);
    end
    tmo_tab[e] = cur[15:0];
  endfunction

  // expected result word for one request
  function automatic verdict_t predict_timeout(logic [63:0] w);
    verdict_t v;
    logic [3:0]  peer;
    logic [2:0]  mod;
    logic [47:0] ts;
    int e;
    v.req = att_pkg::req_t'(w[1:0]);
    peer = w[5:2];
    mod = w[8:6];
    ts = w[56:9];
    e = int'(peer) * att_pkg::MODULES + int'(mod);
    v.timeout_ms = '0;
    v.known = 1'b0;
    v.dropped = 1'b0;
    case (v.req)
      att_pkg::REQ_ADD: begin
        v.known = present[e];
        if (!present[e]) begin
          present[e] = 1'b1;
          tmo_tab[e] = dflt_tmo;
          head[e] = 0;
          cnt[e] = 0;
        end
        if (cnt[e] >= DEPTH) begin
          v.dropped = 1'b1;
        end else begin
          points[e][(head[e] + cnt[e]) % DEPTH] = ts;
          cnt[e]++;
        end
        v.timeout_ms = tmo_tab[e];
      end
      att_pkg::REQ_TICK: begin
        for (int i = 0; i < ENTRIES; i++)
          if (present[i]) adapt_timeout(i, ts);
      end
      att_pkg::REQ_QUERY: begin
        v.known = present[e];
        v.timeout_ms = present[e] ? tmo_tab[e] : dflt_tmo;
      end
      default: begin
        for (int m = 0; m < att_pkg::MODULES; m++) begin
          present[int'(peer) * att_pkg::MODULES + m] = 1'b0;
          head[int'(peer) * att_pkg::MODULES + m] = 0;
          cnt[int'(peer) * att_pkg::MODULES + m] = 0;
        end
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      // start from the reset state
      fail_count = 0;
      checked = 0;
      expected_q.delete();
      dflt_tmo = att_pkg::RST_DEFAULT;
      max_tmo = att_pkg::RST_MAX;
      window = att_pkg::RST_WINDOW;
      threshold = att_pkg::RST_THRESHOLD;
      up_step = att_pkg::RST_RAISE;
      down_step = att_pkg::RST_LOWER;
      for (int i = 0; i < ENTRIES; i++) begin
        present[i] = 1'b0;
        head[i] = 0;
        cnt[i] = 0;
        tmo_tab[i] = '0;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          att_pkg::CFG_DEFAULT:   dflt_tmo = cfg_data;
          att_pkg::CFG_MAX:       max_tmo = cfg_data;
          att_pkg::CFG_WINDOW:    window = cfg_data;
          att_pkg::CFG_THRESHOLD: threshold = cfg_data[7:0];
          att_pkg::CFG_RAISE:     up_step = cfg_data;
          att_pkg::CFG_LOWER:     down_step = cfg_data;
          default: ;
        endcase
      end
      // compare result word with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word %h", $realtime, m_axis_tdata);
        end else begin
          exp_v = expected_q[0];
          expected_q.delete(0);
          if (m_axis_tdata[15:0] !== exp_v.timeout_ms || m_axis_tdata[16] !== exp_v.known ||
              m_axis_tdata[17] !== exp_v.dropped) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: %s mismatch: exp timeout %0d known %0b dropped %0b, got %0d %0b %0b",
                       $realtime, exp_v.req.name(), exp_v.timeout_ms, exp_v.known,
                       exp_v.dropped, m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17]);
          end
        end
      end
      // accepted request word
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_timeout(s_axis_tdata));
    end
    pending = expected_q.size();
  end

endmodule

FILE: tb/tb_adaptive_timeout_table.sv
module tb_adaptive_timeout_table;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes past the last register
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  int fail_count, pending, checked;
  int sent = 0;
  int phases = 0;
  bit no_idle = 1'b0;
  logic [47:0] now_ms = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_timeout_table dut (.*);

  att_checker chk (.*);

  // run limit
  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, one long hold-off midway through the run
  initial begin
    int r;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && sent >= 600) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (no_idle || r < 60) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (r < 95) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // offer one request word and wait for its acceptance
  task automatic send_req(att_pkg::req_t req, logic [3:0] peer, logic [2:0] mod,
                          logic [47:0] ts);
    int r, gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, ts, mod, peer, req};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    r = $urandom_range(0, 99);
    gap = (no_idle || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let every outstanding result come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] dflt, logic [15:0] mx, logic [15:0] win,
                          logic [15:0] thr, logic [15:0] up, logic [15:0] down);
    write_reg(att_pkg::CFG_DEFAULT, dflt);
    write_reg(att_pkg::CFG_MAX, mx);
    write_reg(att_pkg::CFG_WINDOW, win);
    write_reg(att_pkg::CFG_THRESHOLD, thr);
    write_reg(att_pkg::CFG_RAISE, up);
    write_reg(att_pkg::CFG_LOWER, down);
  endtask

  // mostly adds and ticks on a few busy peers with a moving clock, some noise
  task automatic random_phase(int n);
    int r;
    logic [3:0] peer;
    logic [47:0] ts;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      peer = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      if (r < 50) begin
        ts = now_ms + 48'($urandom_range(0, 3000));
        send_req(att_pkg::REQ_ADD, peer, 3'($urandom_range(0, 2)), ts);
      end else if (r < 62) begin
        now_ms = now_ms + 48'($urandom_range(0, 8000));
        send_req(att_pkg::REQ_TICK, peer, 3'($urandom), now_ms);
      end else if (r < 77) begin
        send_req(att_pkg::REQ_QUERY, peer, 3'($urandom), 48'({$urandom, $urandom}));
      end else if (r < 82) begin
        send_req(att_pkg::REQ_REMOVE, peer, 3'($urandom), 48'({$urandom, $urandom}));
      end else begin
        ts = 48'({$urandom, $urandom});
        send_req(att_pkg::req_t'($urandom_range(0, 1)), 4'($urandom), 3'($urandom), ts);
      end
    end
    drain();
    phases++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: absent entry, time extremes, full fifo, removes
    send_req(att_pkg::REQ_QUERY, 4'd0, 3'd0, '0);
    send_req(att_pkg::REQ_ADD, 4'd0, 3'd0, '0);
    send_req(att_pkg::REQ_ADD, 4'd15, 3'd7, '1);
    send_req(att_pkg::REQ_QUERY, 4'd0, 3'd0, '0);
    send_req(att_pkg::REQ_QUERY, 4'd15, 3'd7, '1);
    for (int i = 0; i < 9; i++) send_req(att_pkg::REQ_ADD, 4'd1, 3'd2, 48'(100 * i + 4000));
    send_req(att_pkg::REQ_TICK, 4'd0, 3'd0, 48'd1000);
    send_req(att_pkg::REQ_TICK, 4'd0, 3'd0, 48'd6000);
    send_req(att_pkg::REQ_QUERY, 4'd1, 3'd2, '0);
    send_req(att_pkg::REQ_TICK, 4'd15, 3'd7, '1);
    send_req(att_pkg::REQ_REMOVE, 4'd15, 3'd7, '0);
    send_req(att_pkg::REQ_QUERY, 4'd15, 3'd7, '0);
    send_req(att_pkg::REQ_REMOVE, 4'd0, 3'd0, '0);
    send_req(att_pkg::REQ_QUERY, 4'd0, 3'd0, '0);
    drain();

    // random phases under several register settings
    random_phase(150);
    set_regs(16'd1000, 16'd9000, 16'd10000, 16'd2, 16'd3000, 16'd700);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    random_phase(150);
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(120);
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(120);
    // cap below the current timeout and a lower step wider than the value
    set_regs(16'd20000, 16'd15000, 16'd20000, 16'd1, 16'd4000, 16'hFFFF);
    random_phase(120);
    no_idle = 1'b1;
    set_regs(16'd500, 16'd60000, 16'd8000, 16'd3, 16'd20000, 16'd100);
    random_phase(150);
    no_idle = 1'b0;
    random_phase(150);

    $display("run covered %0d request words and %0d result words over %0d random phases",
             sent, checked, phases);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/att_pkg.sv
hdl/att_ctrl.sv
hdl/att_dp.sv
hdl/adaptive_timeout_table.sv
tb/att_checker.sv
tb/tb_adaptive_timeout_table.sv
